[hdl/tofq_pkg.sv]
// Shared types and constants for the timestamp-ordered frame queue.
// Used by tofq_ctrl and the top level; depends on nothing.
`default_nettype none

package tofq_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int REQ_W      = 2;
  localparam int HANDLE_W   = 16;
  localparam int STAMP_W    = 64;
  localparam int OCC_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int IN_TDATA_W = 80;
  localparam int TDATA_W    = 88;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_FLUSH = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GETD,
    S_SCAN,
    S_INS,
    S_DONE
  } tofq_state_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
    logic [OCC_W-1:0]    occ;
  } tofq_res_t;

endpackage

`default_nettype wire

[hdl/tofq_ram.sv]
// Simple dual-port entry memory: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module tofq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/tofq_ctrl.sv]
// Request sequencer: circular sorted list over tofq_ram, insertion by backward scan.
// Depends on tofq_pkg.
`default_nettype none

module tofq_ctrl #(
  parameter int QUEUE_DEPTH = 32,
  parameter int HANDLE_BITS = 16,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int MW = tofq_pkg::STAMP_W + HANDLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tofq_pkg::REQ_W-1:0]    in_req,
  input  wire logic [tofq_pkg::HANDLE_W-1:0] in_handle,
  input  wire logic [tofq_pkg::STAMP_W-1:0]  in_stamp,
  output tofq_pkg::tofq_res_t                res,
  input  wire logic                          res_take,
  output logic                               mem_wr_en,
  output logic      [AW-1:0]                 mem_wr_addr,
  output logic      [MW-1:0]                 mem_wr_data,
  output logic                               mem_rd_en,
  output logic      [AW-1:0]                 mem_rd_addr,
  input  wire logic [MW-1:0]                 mem_rd_data
);

  import tofq_pkg::*;

  tofq_state_t             state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [REQ_W-1:0]        req_r, req_nxt;
  logic [HANDLE_BITS-1:0]  hnd_r, hnd_nxt;
  logic [STAMP_W-1:0]      stamp_r, stamp_nxt;
  tofq_res_t               res_r, res_nxt;

  logic [STAMP_W-1:0]      rd_stamp;
  logic [HANDLE_BITS-1:0]  rd_hnd;
  logic                    rd_later;

  // Logical slot (offset from head) to physical address, wrapping at the depth.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] lg);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(lg);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] occ_of(input logic [CW-1:0] c);
    logic [OCC_W-1:0] o;
    o = '0;
    for (int b = 0; b < OCC_W && b < CW; b++) begin
      o[b] = c[b];
    end
    return o;
  endfunction

  function automatic logic [HANDLE_W-1:0] hnd_out(input logic [HANDLE_BITS-1:0] h);
    logic [HANDLE_W-1:0] o;
    o = '0;
    for (int b = 0; b < HANDLE_W && b < HANDLE_BITS; b++) begin
      o[b] = h[b];
    end
    return o;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] hnd_in(input logic [HANDLE_W-1:0] h);
    logic [HANDLE_BITS-1:0] o;
    o = '0;
    for (int b = 0; b < HANDLE_W && b < HANDLE_BITS; b++) begin
      o[b] = h[b];
    end
    return o;
  endfunction

  assign rd_stamp = mem_rd_data[MW-1 -: STAMP_W];
  assign rd_hnd   = mem_rd_data[HANDLE_BITS-1:0];
  assign rd_later = $signed(rd_stamp) > $signed(stamp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      res_r.valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    req_r        <= req_nxt;
    hnd_r        <= hnd_nxt;
    stamp_r      <= stamp_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    req_nxt     = req_r;
    hnd_nxt     = hnd_r;
    stamp_nxt   = stamp_r;
    res_nxt     = res_r;
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = phys(head_r, idx_r);
    mem_wr_data = {stamp_r, hnd_r};
    mem_rd_en   = 1'b0;
    mem_rd_addr = phys(head_r, '0);

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_req;
          hnd_nxt   = hnd_in(in_handle);
          stamp_nxt = in_stamp;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_nxt.status = ST_OK;
        res_nxt.handle = '0;
        res_nxt.stamp  = '0;
        res_nxt.occ    = occ_of(count_r);
        state_nxt      = S_DONE;
        case (req_r)
          REQ_PUT: begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              res_nxt.status = ST_FULL;
            end else if (count_r == '0) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = phys(head_r, '0);
              count_nxt   = CW'(1);
              res_nxt.occ = occ_of(CW'(1));
            end else begin
              // scan backward from the tail, one slot per cycle
              mem_rd_en   = 1'b1;
              mem_rd_addr = phys(head_r, count_r - CW'(1));
              idx_nxt     = count_r;
              state_nxt   = S_SCAN;
            end
          end
          REQ_GET: begin
            if (count_r == '0) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = phys(head_r, '0);
              state_nxt   = S_GETD;
            end
          end
          REQ_FLUSH: begin
            count_nxt   = '0;
            res_nxt.occ = '0;
          end
          default: ;
        endcase
        res_nxt.valid = (state_nxt == S_DONE);
      end

      S_GETD: begin
        res_nxt.valid  = 1'b1;
        res_nxt.handle = hnd_out(rd_hnd);
        res_nxt.stamp  = rd_stamp;
        head_nxt       = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
        count_nxt      = count_r - CW'(1);
        res_nxt.occ    = occ_of(count_r - CW'(1));
        state_nxt      = S_DONE;
      end

      S_SCAN: begin
        mem_wr_en = 1'b1;
        if (rd_later) begin
          // move the later entry up one slot
          mem_wr_data = mem_rd_data;
          idx_nxt     = idx_r - CW'(1);
          if (idx_r == CW'(1)) begin
            state_nxt = S_INS;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = phys(head_r, idx_r - CW'(2));
          end
        end else begin
          count_nxt     = count_r + CW'(1);
          res_nxt.valid = 1'b1;
          res_nxt.occ   = occ_of(count_r + CW'(1));
          state_nxt     = S_DONE;
        end
      end

      S_INS: begin
        mem_wr_en     = 1'b1;
        count_nxt     = count_r + CW'(1);
        res_nxt.valid = 1'b1;
        res_nxt.occ   = occ_of(count_r + CW'(1));
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          res_nxt.valid = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign res = res_r;

endmodule

`default_nettype wire

[hdl/timestamp_ordered_frame_queue.sv]
// Top level of the timestamp-ordered frame queue: stream ports, output register.
// Depends on tofq_pkg, tofq_ram and tofq_ctrl.
`default_nettype none

// Holds up to QUEUE_DEPTH frame handles sorted by signed 64-bit timestamp, kept
// as a circular list in one entry memory. A get takes the head, read from the
// memory. A flush, a put into a full or empty queue, a get from an empty queue
// and an unknown request code are settled in the decode state. A put into a
// non-empty queue scans backward from the tail through the memory, moving one
// later entry per cycle. One request is in flight at a time; the next input
// transfer is taken once the result has moved into the output register. Each
// request gives exactly one result.
module timestamp_ordered_frame_queue #(
  parameter int QUEUE_DEPTH = tofq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = tofq_pkg::DEF_HANDLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tofq_pkg::IN_TDATA_W-1:0] in_tdata, // frame_handle[15:0],
                                                         // timestamp[79:16]
  input  wire logic [tofq_pkg::REQ_W-1:0]    in_tuser,   // req_type[1:0]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [tofq_pkg::TDATA_W-1:0]  out_tdata,  // out_handle[15:0],
                                                         // out_timestamp[79:16],
                                                         // occupancy[85:80]
  output logic      [tofq_pkg::STATUS_W-1:0] out_tuser   // status[1:0]
);

  import tofq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int MW = STAMP_W + HANDLE_BITS;

  tofq_res_t              res;
  logic                   res_take;
  logic                   out_free;
  logic                   out_valid_r;
  logic [TDATA_W-1:0]     out_data_r;
  logic [STATUS_W-1:0]    out_user_r;

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [MW-1:0]          mem_wr_data;
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [MW-1:0]          mem_rd_data;

  tofq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (MW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  tofq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req      (in_tuser),
    .in_handle   (in_tdata[HANDLE_W-1:0]),
    .in_stamp    (in_tdata[HANDLE_W +: STAMP_W]),
    .res         (res),
    .res_take    (res_take),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  assign out_free = !out_valid_r || out_tready;
  assign res_take = res.valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= {{(TDATA_W - HANDLE_W - STAMP_W - OCC_W){1'b0}},
                     res.occ, res.stamp, res.handle};
      out_user_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // failed requests carry no frame
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_EMPTY)
      |-> out_tdata[HANDLE_W+STAMP_W-1:0] == '0)
    else $error("failed request returned frame data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_FULL || out_tuser == ST_EMPTY))
    else $error("undefined status code");

  // sequencer is idle only with no result pending
  a_idle_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res.valid)
    else $error("input ready while a result is pending");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

endmodule

`default_nettype wire
